FILE: rtl/core/mwc_pkg.sv
// ----------------------------------------------------------------------------
// mwc_pkg
// Shared constants, types and helpers for the rank-sum arrangement counter.
// ----------------------------------------------------------------------------
package mwc_pkg;

  localparam int MAX_SIZE    = 16;
  localparam int HALF_RANGE  = (MAX_SIZE * MAX_SIZE) / 2;
  localparam int ROW_LEN     = HALF_RANGE + 1;
  localparam int TABLE_DEPTH = (MAX_SIZE + 1) * ROW_LEN;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam int STAT_W  = 9;
  localparam int SIZE_W  = 5;
  localparam int COUNT_W = 30;
  localparam int PROD_W  = 2 * SIZE_W;
  localparam int KK_W    = $clog2(HALF_RANGE + 1);
  localparam int ROW_W   = $clog2(MAX_SIZE + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_COMPUTE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_UPDATE,
    OP_RESULT,
    OP_ZERO
  } op_t;

  // Per-cycle table access issued by the sequencer
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              use_a;
    op_t               op;
    logic [ADDR_W-1:0] tgt;
    logic              init_we;
    logic [ADDR_W-1:0] init_addr;
    logic              init_one;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic [COUNT_W-1:0] count;
  } res_t;

  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] row);
    return ADDR_W'(int'(row) * ROW_LEN);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/mwc_if.sv
// ----------------------------------------------------------------------------
// mwc_in_if / mwc_out_if
// Valid/ready channels for queries and counts.
// ----------------------------------------------------------------------------
interface mwc_in_if;
  logic                        valid;
  logic                        ready;
  logic [mwc_pkg::STAT_W-1:0]  stat_value;
  logic [mwc_pkg::SIZE_W-1:0]  size_a;
  logic [mwc_pkg::SIZE_W-1:0]  size_b;

  modport source (output valid, stat_value, size_a, size_b, input ready);
  modport sink   (input valid, stat_value, size_a, size_b, output ready);
endinterface

interface mwc_out_if;
  logic                        valid;
  logic                        ready;
  logic [mwc_pkg::COUNT_W-1:0] arrangement_count;

  modport source (output valid, arrangement_count, input ready);
  modport sink   (input valid, arrangement_count, output ready);
endinterface

FILE: rtl/core/mann_whitney_count.sv
// ----------------------------------------------------------------------------
// mann_whitney_count
// Exact count of rank arrangements giving a rank-sum statistic value,
// built per query in a scratch table held in block RAM.
// ----------------------------------------------------------------------------
//  channel  dir  beat fields
//  query    in   stat_value[8:0], size_a[4:0], size_b[4:0]
//  result   out  arrangement_count[29:0]
//
// One query at a time. With k' the folded statistic, s = min and b = max of
// the sizes, the sequencer seeds (b+1)*(k'+1) entries, then makes s*b*(k'+1)
// updates and a final read, paced by the single table write port (one entry
// written per cycle). Out-of-range queries skip the table.
// Reset is synchronous; the table needs no clearing, every entry is seeded
// before use. A stalled result beat holds the final read until it drains.
// ----------------------------------------------------------------------------
module mann_whitney_count (
  input  logic      clk,
  input  logic      rst,
  mwc_in_if.sink    query,
  mwc_out_if.source result
);

  mwc_pkg::cmd_t cmd;
  mwc_pkg::res_t res;

  logic                        wr_en;
  logic [mwc_pkg::ADDR_W-1:0]  wr_addr;
  logic [mwc_pkg::COUNT_W-1:0] wr_data;
  logic [mwc_pkg::COUNT_W-1:0] ra_data, rb_data;

  logic                        out_valid;
  logic [mwc_pkg::COUNT_W-1:0] out_count;
  logic                        out_free;

  assign out_free = !out_valid || result.ready;

  mwc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .query    (query),
    .out_free (out_free),
    .cmd      (cmd)
  );

  mwc_ram #(
    .WIDTH (mwc_pkg::COUNT_W),
    .DEPTH (mwc_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .ra_addr (cmd.addr_a),
    .rb_addr (cmd.addr_b),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  mwc_upd u_upd (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .ra_data (ra_data),
    .rb_data (rb_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res     (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_count <= res.count;
    end
  end

  assign result.valid             = out_valid;
  assign result.arrangement_count = out_count;

  // A finished count only lands in an empty output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !out_valid)
    else $error("result overwrote a pending beat");

  // One result per query: none right after a new query is taken
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (query.valid && query.ready) |=> !res.valid)
    else $error("unexpected result after query accept");

  a_rd_addr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (cmd.addr_a < mwc_pkg::ADDR_W'(mwc_pkg::TABLE_DEPTH)) &&
                  (cmd.addr_b < mwc_pkg::ADDR_W'(mwc_pkg::TABLE_DEPTH)))
    else $error("table read out of range");

  a_wr_addr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_addr < mwc_pkg::ADDR_W'(mwc_pkg::TABLE_DEPTH)))
    else $error("table write out of range");

endmodule

FILE: rtl/core/mwc_ram.sv
// ----------------------------------------------------------------------------
// mwc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         ra_data,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

FILE: rtl/core/mwc_seq.sv
// ----------------------------------------------------------------------------
// mwc_seq
// Query decode and table sequencer: folds k, seeds the table, then walks
// part count, part bound and value, issuing one table update per cycle.
// ----------------------------------------------------------------------------
module mwc_seq (
  input  logic          clk,
  input  logic          rst,
  mwc_in_if.sink        query,
  input  logic          out_free,
  output mwc_pkg::cmd_t cmd
);

  mwc_pkg::state_t state, state_next;

  logic [mwc_pkg::KK_W-1:0]  k_q, k_next;
  logic [mwc_pkg::ROW_W-1:0] small_q, small_next;
  logic [mwc_pkg::ROW_W-1:0] big_q, big_next;
  logic                      zero_q, zero_next;
  logic [mwc_pkg::ROW_W-1:0] ii, ii_next;
  logic [mwc_pkg::ROW_W-1:0] jj, jj_next;
  logic [mwc_pkg::KK_W-1:0]  kk, kk_next;

  // Query decode
  logic                       over;
  logic [mwc_pkg::PROD_W-1:0] u, kx, fold;
  logic                       out_range;
  logic [mwc_pkg::ADDR_W-1:0] kk_x, jj_x;

  always_comb begin
    over = (query.size_a > mwc_pkg::SIZE_W'(mwc_pkg::MAX_SIZE)) ||
           (query.size_b > mwc_pkg::SIZE_W'(mwc_pkg::MAX_SIZE));
    u    = mwc_pkg::PROD_W'(query.size_a) * mwc_pkg::PROD_W'(query.size_b);
    kx   = mwc_pkg::PROD_W'(query.stat_value);
    out_range = over || (kx > u);
    // Fold about the centre of the distribution
    fold = (kx > (u >> 1)) ? (u - kx) : kx;
  end

  assign kk_x = mwc_pkg::ADDR_W'(kk);
  assign jj_x = mwc_pkg::ADDR_W'(jj);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    k_q     <= k_next;
    small_q <= small_next;
    big_q   <= big_next;
    zero_q  <= zero_next;
    ii      <= ii_next;
    jj      <= jj_next;
    kk      <= kk_next;
  end

  always_comb begin
    state_next  = state;
    k_next      = k_q;
    small_next  = small_q;
    big_next    = big_q;
    zero_next   = zero_q;
    ii_next     = ii;
    jj_next     = jj;
    kk_next     = kk;
    cmd         = '0;
    cmd.op      = mwc_pkg::OP_NONE;
    query.ready = (state == mwc_pkg::ST_IDLE);

    case (state)
      mwc_pkg::ST_IDLE: begin
        if (query.valid) begin
          k_next     = mwc_pkg::KK_W'(fold);
          small_next = mwc_pkg::ROW_W'((query.size_a < query.size_b) ?
                                       query.size_a : query.size_b);
          big_next   = mwc_pkg::ROW_W'((query.size_a < query.size_b) ?
                                       query.size_b : query.size_a);
          zero_next  = out_range;
          jj_next    = '0;
          kk_next    = '0;
          state_next = out_range ? mwc_pkg::ST_FINISH : mwc_pkg::ST_INIT;
        end
      end

      mwc_pkg::ST_INIT: begin
        // Seed rows 0..big: only value zero is reachable with no parts
        cmd.init_we   = 1'b1;
        cmd.init_addr = mwc_pkg::row_base(jj) + kk_x;
        cmd.init_one  = (kk == '0);
        if (kk == k_q) begin
          kk_next = '0;
          if (jj == big_q) begin
            if (small_q == '0) begin
              state_next = mwc_pkg::ST_FINISH;
            end else begin
              state_next = mwc_pkg::ST_COMPUTE;
              ii_next    = mwc_pkg::ROW_W'(1);
              jj_next    = mwc_pkg::ROW_W'(1);
              kk_next    = k_q;
            end
          end else begin
            jj_next = jj + 1'b1;
          end
        end else begin
          kk_next = kk + 1'b1;
        end
      end

      mwc_pkg::ST_COMPUTE: begin
        // Descending value keeps row[kk-jj] at its previous part-count value
        cmd.rd_en  = 1'b1;
        cmd.use_a  = (kk_x >= jj_x);
        cmd.addr_a = cmd.use_a ? (mwc_pkg::row_base(jj) + kk_x - jj_x) : '0;
        cmd.addr_b = mwc_pkg::row_base(mwc_pkg::ROW_W'(jj - 1'b1)) + kk_x;
        cmd.op     = mwc_pkg::OP_UPDATE;
        cmd.tgt    = mwc_pkg::row_base(jj) + kk_x;
        if (kk == '0) begin
          kk_next = k_q;
          if (jj == big_q) begin
            jj_next = mwc_pkg::ROW_W'(1);
            if (ii == small_q) begin
              state_next = mwc_pkg::ST_FINISH;
            end else begin
              ii_next = ii + 1'b1;
            end
          end else begin
            jj_next = jj + 1'b1;
          end
        end else begin
          kk_next = kk - 1'b1;
        end
      end

      mwc_pkg::ST_FINISH: begin
        // Hold until the output register can take the beat
        if (out_free) begin
          cmd.rd_en  = !zero_q;
          cmd.addr_a = zero_q ? '0 : (mwc_pkg::row_base(big_q) +
                                      mwc_pkg::ADDR_W'(k_q));
          cmd.addr_b = '0;
          cmd.op     = zero_q ? mwc_pkg::OP_ZERO : mwc_pkg::OP_RESULT;
          state_next = mwc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mwc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/mwc_upd.sv
// ----------------------------------------------------------------------------
// mwc_upd
// Read-modify-write unit: takes the table read data, forwards a write that
// lands on a just-read entry, adds with saturation and writes back.
// ----------------------------------------------------------------------------
module mwc_upd (
  input  logic                        clk,
  input  logic                        rst,
  input  mwc_pkg::cmd_t               cmd,
  input  logic [mwc_pkg::COUNT_W-1:0] ra_data,
  input  logic [mwc_pkg::COUNT_W-1:0] rb_data,
  output logic                        wr_en,
  output logic [mwc_pkg::ADDR_W-1:0]  wr_addr,
  output logic [mwc_pkg::COUNT_W-1:0] wr_data,
  output mwc_pkg::res_t               res
);

  mwc_pkg::op_t               op_q;
  logic [mwc_pkg::ADDR_W-1:0] tgt_q;
  logic                       use_a_q;
  logic                       hit_a_q, hit_b_q;
  logic [mwc_pkg::COUNT_W-1:0] fwd_q;
  logic [mwc_pkg::COUNT_W-1:0] a, b;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= mwc_pkg::OP_NONE;
    end else begin
      op_q <= cmd.op;
    end
  end

  // A read that meets a write to the same entry saw the old word: keep the new
  always_ff @(posedge clk) begin
    tgt_q   <= cmd.tgt;
    use_a_q <= cmd.use_a;
    hit_a_q <= cmd.rd_en && wr_en && (cmd.addr_a == wr_addr);
    hit_b_q <= cmd.rd_en && wr_en && (cmd.addr_b == wr_addr);
    fwd_q   <= wr_data;
  end

  assign a = hit_a_q ? fwd_q : ra_data;
  assign b = hit_b_q ? fwd_q : rb_data;

  always_comb begin
    if (op_q == mwc_pkg::OP_UPDATE) begin
      wr_en   = 1'b1;
      wr_addr = tgt_q;
      wr_data = use_a_q ? mwc_pkg::sat_add(a, b) : b;
    end else begin
      wr_en   = cmd.init_we;
      wr_addr = cmd.init_addr;
      wr_data = mwc_pkg::COUNT_W'(cmd.init_one);
    end
  end

  always_comb begin
    res.valid = (op_q == mwc_pkg::OP_RESULT) || (op_q == mwc_pkg::OP_ZERO);
    res.count = (op_q == mwc_pkg::OP_RESULT) ? a : '0;
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rank-sum arrangement counter. Directed queries
// cover empty samples, out-of-range statistics, oversize samples and the full
// 16 by 16 table. Random queries follow, mostly small sizes, with random
// gaps on both channels and one stretch at full rate. A local dynamic
// programming predictor gives the expected count of every query beat.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_HALF    = 10;
  localparam int CYCLE_LIMIT = 15000000;
  localparam int IDLE_PCT    = 36;
  localparam int DRAIN_TAIL  = 40;

  typedef struct {
    logic [mwc_pkg::STAT_W-1:0]  k;
    logic [mwc_pkg::SIZE_W-1:0]  m;
    logic [mwc_pkg::SIZE_W-1:0]  n;
    logic [mwc_pkg::COUNT_W-1:0] count;
  } count_query_t;

  logic clk;
  logic rst;
  int   error_count;
  int   cycle_count;
  bit   idle_on;

  count_query_t pending_counts[$];

  mwc_in_if  query_ch ();
  mwc_out_if result_ch ();

  mann_whitney_count dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Partitions of k into at most min(m,n) parts, each at most max(m,n)
  function automatic logic [mwc_pkg::COUNT_W-1:0] count_rank_arrangements(
      input logic [mwc_pkg::STAT_W-1:0] k_in,
      input logic [mwc_pkg::SIZE_W-1:0] m,
      input logic [mwc_pkg::SIZE_W-1:0] n);
    logic [mwc_pkg::COUNT_W-1:0] ways [0:mwc_pkg::MAX_SIZE][0:mwc_pkg::HALF_RANGE];
    logic [mwc_pkg::COUNT_W:0]   sum;
    int                          k, span, fewer, wider;
    if (m > mwc_pkg::MAX_SIZE || n > mwc_pkg::MAX_SIZE)
      return '0;
    span = int'(m) * int'(n);
    k    = int'(k_in);
    if (k > span)
      return '0;
    if (k > span / 2)
      k = span - k;
    fewer = (m < n) ? int'(m) : int'(n);
    wider = (m < n) ? int'(n) : int'(m);
    for (int j = 0; j <= wider; j++)
      for (int kk = 0; kk <= k; kk++)
        ways[j][kk] = (kk == 0) ? mwc_pkg::COUNT_W'(1) : '0;
    for (int i = 1; i <= fewer; i++) begin
      for (int j = 1; j <= wider; j++) begin
        // walk k downwards so ways[j][kk-j] still holds the previous part count
        for (int kk = k; kk >= 0; kk--) begin
          if (kk >= j) begin
            sum = {1'b0, ways[j][kk-j]} + {1'b0, ways[j-1][kk]};
            ways[j][kk] = (sum > {1'b0, mwc_pkg::COUNT_MAX}) ? mwc_pkg::COUNT_MAX :
                                                              sum[mwc_pkg::COUNT_W-1:0];
          end else begin
            ways[j][kk] = ways[j-1][kk];
          end
        end
      end
    end
    return ways[wider][k];
  endfunction

  task automatic report_mismatch(input string what, input count_query_t q,
                                 input logic [mwc_pkg::COUNT_W-1:0] got);
    $display("MISMATCH %s: k=%0d m=%0d n=%0d got %0d expected %0d at cycle %0d",
             what, q.k, q.m, q.n, got, q.count, cycle_count);
    error_count++;
  endtask

  task automatic quiet_query();
    query_ch.valid <= 1'b0;
  endtask

  // Valid is left high after a beat so back-to-back queries need no gap
  task automatic send_query(input logic [mwc_pkg::STAT_W-1:0] k,
                            input logic [mwc_pkg::SIZE_W-1:0] m,
                            input logic [mwc_pkg::SIZE_W-1:0] n);
    count_query_t q;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      quiet_query();
      @(posedge clk);
    end
    q.k     = k;
    q.m     = m;
    q.n     = n;
    q.count = count_rank_arrangements(k, m, n);
    pending_counts.push_back(q);
    query_ch.valid      <= 1'b1;
    query_ch.stat_value <= k;
    query_ch.size_a     <= m;
    query_ch.size_b     <= n;
    do @(posedge clk); while (!(query_ch.valid && query_ch.ready));
  endtask

  task automatic test_empty_samples();
    send_query(9'd0, 5'd0, 5'd0);
    send_query(9'd1, 5'd0, 5'd5);
    send_query(9'd0, 5'd9, 5'd0);
    send_query(9'd0, 5'd16, 5'd0);
  endtask

  task automatic test_out_of_range();
    send_query(9'd17, 5'd4, 5'd4);
    send_query(9'd16, 5'd4, 5'd4);
    send_query(9'd511, 5'd16, 5'd16);
    send_query(9'd257, 5'd16, 5'd16);
    send_query(9'd256, 5'd16, 5'd16);
  endtask

  task automatic test_oversize();
    send_query(9'd0, 5'd17, 5'd2);
    send_query(9'd5, 5'd31, 5'd31);
    send_query(9'd3, 5'd2, 5'd24);
    send_query(9'd0, 5'd16, 5'd17);
    send_query(9'd255, 5'd31, 5'd0);
  endtask

  task automatic test_shapes();
    send_query(9'd8, 5'd1, 5'd16);
    send_query(9'd8, 5'd16, 5'd1);
    send_query(9'd7, 5'd5, 5'd3);
    send_query(9'd7, 5'd3, 5'd5);
  endtask

  // Centre of the widest distribution, both with and without the fold
  task automatic test_full_table();
    send_query(9'd128, 5'd16, 5'd16);
    send_query(9'd129, 5'd16, 5'd16);
  endtask

  task automatic send_random_query();
    int sel, m, n, k;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      m = $urandom_range(0, 6);
      n = $urandom_range(0, 6);
      k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, m * n) : $urandom_range(0, 511);
    end else if (sel < 90) begin
      m = $urandom_range(0, 4);
      n = $urandom_range(0, 16);
      if ($urandom_range(0, 1)) begin
        k = m;
        m = n;
        n = k;
      end
      k = $urandom_range(0, m * n);
    end else if (sel < 95) begin
      m = $urandom_range(17, 31);
      n = $urandom_range(0, 31);
      if ($urandom_range(0, 1)) begin
        k = m;
        m = n;
        n = k;
      end
      k = $urandom_range(0, 511);
    end else begin
      m = $urandom_range(0, 16);
      n = $urandom_range(0, 16);
      k = $urandom_range(0, 511);
    end
    send_query(mwc_pkg::STAT_W'(k), mwc_pkg::SIZE_W'(m), mwc_pkg::SIZE_W'(n));
  endtask

  task automatic test_random_mixed();
    repeat (50) send_random_query();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (30) send_random_query();
    idle_on = 1'b1;
  endtask

  // Result sink: check each beat, then pick ready for the next edge
  initial begin
    count_query_t head;
    head = '{default: '0};
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (pending_counts.size() == 0) begin
          report_mismatch("result beat with no query outstanding", head,
                          result_ch.arrangement_count);
        end else begin
          head = pending_counts.pop_front();
          if (result_ch.arrangement_count !== head.count)
            report_mismatch("arrangement_count", head, result_ch.arrangement_count);
        end
      end
      result_ch.ready <= rst ? 1'b0 : (!idle_on || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    count_query_t left;
    error_count         = 0;
    idle_on             = 1'b1;
    rst                 = 1'b1;
    query_ch.valid      = 1'b0;
    query_ch.stat_value = '0;
    query_ch.size_a     = '0;
    query_ch.size_b     = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_samples();
    test_out_of_range();
    test_oversize();
    test_shapes();
    test_full_table();
    test_random_mixed();
    test_back_to_back();

    quiet_query();
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    while (pending_counts.size() != 0) begin
      left = pending_counts.pop_front();
      report_mismatch("no result for query", left, '0);
    end

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
